### design/tle_pkg.sv
// ----------------------------------------------------------------------------
// tle_pkg: shared types and constants for the terminal line edit buffer
// Control characters, echo codes and the result word carried to the output
// register.
// ----------------------------------------------------------------------------
package tle_pkg;

    // Control characters recognized by the line discipline
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_NL  = 8'h0A;

    // Echo codes
    localparam logic [1:0] ECHO_NONE = 2'd0;
    localparam logic [1:0] ECHO_BYTE = 2'd1;
    localparam logic [1:0] ECHO_NL   = 2'd2;
    localparam logic [1:0] ECHO_BS   = 2'd3;

    // Width of the read limit field and of the byte counters
    localparam int LIM_W = 7;

    // One result word
    typedef struct packed {
        logic [1:0] echo_code;
        logic [7:0] echo_byte;
        logic       wake_reader;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       line_ready;
        logic       last;
    } t_result;

endpackage

### design/tty_line_edit_buffer.sv
// ----------------------------------------------------------------------------
// tty_line_edit_buffer: canonical-mode terminal line buffer
// A key word gives one result word, which passes the S_ONE state and then the
// output register. A read word walks the store twice through one registered
// read port: a scan pass finds where the read stops, then an emit pass returns
// the bytes, one result word per byte, and waits while the output is stalled.
// The input is stalled while a word is in progress. No clearing pass after
// reset.
// ----------------------------------------------------------------------------
module tty_line_edit_buffer #(
    parameter int STORE_DEPTH = 128,
    parameter int MAX_READ    = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_req_type,
    input  logic [7:0] i_key_byte,
    input  logic [6:0] i_read_limit,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_echo_code,
    output logic [7:0] o_echo_byte,
    output logic       o_wake_reader,
    output logic [7:0] o_read_byte,
    output logic       o_read_valid,
    output logic       o_line_ready,
    output logic       o_last
);
    import tle_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam logic [AW-1:0] PTR_LAST = AW'(STORE_DEPTH - 1);
    localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_READ);

    // sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_ONE     = 3'd1;
    localparam logic [2:0] S_SC_RD   = 3'd2;
    localparam logic [2:0] S_SC_CHK  = 3'd3;
    localparam logic [2:0] S_EM_RD   = 3'd4;
    localparam logic [2:0] S_EM_PUSH = 3'd5;

    function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] x);
        return (x == PTR_LAST) ? '0 : x + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_prev(input logic [AW-1:0] x);
        return (x == '0) ? PTR_LAST : x - 1'b1;
    endfunction

    logic [2:0]       r_state, n_state;
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [AW-1:0]    r_ck_ptr, n_ck_ptr;
    logic             r_full, n_full;
    logic [AW-1:0]    r_it, n_it;
    logic [AW-1:0]    r_start, n_start;
    logic [LIM_W-1:0] r_limit, n_limit;
    logic [LIM_W-1:0] r_n, n_n;
    logic [LIM_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_echo_code, n_echo_code;
    logic [7:0]       r_echo_byte, n_echo_byte;
    logic             r_wake, n_wake;

    logic             in_acc;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [7:0]       rd_data;
    logic             push;
    t_result          push_data;
    logic             out_free;

    // key decode helpers
    logic             last_slot;
    logic             take;
    logic [7:0]       c;
    logic [LIM_W-1:0] lim;
    logic [LIM_W-1:0] n_inc;
    logic             fin;
    logic [AW-1:0]    fin_ptr;
    logic             em_last;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign c         = i_key_byte;
    assign last_slot = (r_wr_ptr == ptr_prev(r_rd_ptr));
    assign lim       = (i_read_limit > MAX_LIM) ? MAX_LIM : i_read_limit;
    assign n_inc     = r_n + 1'b1;
    assign em_last   = ((r_cnt + 1'b1) == r_n);

    always_comb begin
        take = 1'b1;
        if (r_full && c != CH_ETX && c != CH_BS) begin
            take = 1'b0;
        end
        if (take && last_slot && c != CH_NL && c != CH_BS && c != CH_ETX) begin
            take = 1'b0;
        end
    end

    // sequencer and pointer updates
    always_comb begin
        n_state     = r_state;
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_ck_ptr    = r_ck_ptr;
        n_full      = r_full;
        n_it        = r_it;
        n_start     = r_start;
        n_limit     = r_limit;
        n_n         = r_n;
        n_cnt       = r_cnt;
        n_echo_code = r_echo_code;
        n_echo_byte = r_echo_byte;
        n_wake      = r_wake;
        wr_en       = 1'b0;
        wr_addr     = r_wr_ptr;
        wr_data     = c;
        rd_en       = 1'b0;
        push        = 1'b0;
        fin         = 1'b0;
        fin_ptr     = r_it;
        push_data   = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc && !i_req_type) begin
                    n_echo_code = ECHO_NONE;
                    n_echo_byte = 8'h00;
                    n_wake      = 1'b0;
                    n_state     = S_ONE;
                    if (take && last_slot && c == CH_NL) begin
                        n_full = 1'b1;
                    end
                    if (take) begin
                        if (c == CH_NL || c == CH_EOT) begin
                            wr_en    = 1'b1;
                            n_wr_ptr = ptr_next(r_wr_ptr);
                            n_ck_ptr = ptr_next(r_wr_ptr);
                            n_wake   = 1'b1;
                            if (c == CH_NL) begin
                                n_echo_code = ECHO_NL;
                            end
                        end else if (c == CH_ETX) begin
                            // drop raw line, leave a blank cooked line
                            wr_en    = 1'b1;
                            wr_addr  = r_ck_ptr;
                            wr_data  = CH_NL;
                            n_wr_ptr = ptr_next(r_ck_ptr);
                            n_ck_ptr = ptr_next(r_ck_ptr);
                        end else if (c == CH_BS) begin
                            if (r_wr_ptr != r_ck_ptr) begin
                                n_wr_ptr    = ptr_prev(r_wr_ptr);
                                n_echo_code = ECHO_BS;
                            end
                        end else begin
                            wr_en       = 1'b1;
                            n_wr_ptr    = ptr_next(r_wr_ptr);
                            n_echo_code = ECHO_BYTE;
                            n_echo_byte = c;
                        end
                    end
                end else if (in_acc) begin
                    n_echo_code = ECHO_NONE;
                    n_echo_byte = 8'h00;
                    n_wake      = 1'b0;
                    n_limit     = lim;
                    n_it        = r_rd_ptr;
                    n_start     = r_rd_ptr;
                    n_n         = '0;
                    n_state     = (lim == '0) ? S_ONE : S_SC_RD;
                end
            end

            // single result word: key result or empty read
            S_ONE: begin
                push                  = 1'b1;
                push_data.echo_code   = r_echo_code;
                push_data.echo_byte   = r_echo_byte;
                push_data.wake_reader = r_wake;
                push_data.line_ready  = (r_rd_ptr != r_ck_ptr);
                push_data.last        = 1'b1;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end

            // scan pass: look at one byte
            S_SC_RD: begin
                if (r_it == r_ck_ptr) begin
                    fin     = 1'b1;
                    fin_ptr = r_it;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_SC_CHK;
                end
            end

            S_SC_CHK: begin
                n_it = ptr_next(r_it);
                if (rd_data == CH_EOT) begin
                    fin     = 1'b1;
                    fin_ptr = ptr_next(r_it);
                end else begin
                    n_n = n_inc;
                    if (rd_data == CH_NL || n_inc >= r_limit) begin
                        fin     = 1'b1;
                        fin_ptr = ptr_next(r_it);
                    end else begin
                        n_state = S_SC_RD;
                    end
                end
            end

            // emit pass: fetch, then hand over one byte
            S_EM_RD: begin
                rd_en   = 1'b1;
                n_state = S_EM_PUSH;
            end

            S_EM_PUSH: begin
                push                 = 1'b1;
                push_data.read_byte  = rd_data;
                push_data.read_valid = 1'b1;
                push_data.line_ready = (r_rd_ptr != r_ck_ptr);
                push_data.last       = em_last;
                if (out_free) begin
                    n_cnt   = r_cnt + 1'b1;
                    n_it    = ptr_next(r_it);
                    n_state = em_last ? S_IDLE : S_EM_RD;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // end of scan: commit read pointer, then emit the bytes or give an empty result
        if (fin) begin
            n_rd_ptr = fin_ptr;
            if (n_n != '0) begin
                n_full  = 1'b0;
                n_it    = r_start;
                n_cnt   = '0;
                n_state = S_EM_RD;
            end else begin
                n_state = S_ONE;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_ck_ptr <= '0;
            r_full   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_ck_ptr <= n_ck_ptr;
            r_full   <= n_full;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_it        <= n_it;
        r_start     <= n_start;
        r_limit     <= n_limit;
        r_n         <= n_n;
        r_cnt       <= n_cnt;
        r_echo_code <= n_echo_code;
        r_echo_byte <= n_echo_byte;
        r_wake      <= n_wake;
    end

    tle_store #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_it),
        .o_rd_data(rd_data)
    );

    tle_out_reg u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_data       (push_data),
        .o_free       (out_free),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_echo_code  (o_echo_code),
        .o_echo_byte  (o_echo_byte),
        .o_wake_reader(o_wake_reader),
        .o_read_byte  (o_read_byte),
        .o_read_valid (o_read_valid),
        .o_line_ready (o_line_ready),
        .o_last       (o_last)
    );

    // store is written only when a key word is taken
    a_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_IDLE && in_acc && !i_req_type))
        else $error("store written outside key handling");

    // scan never counts past the limit
    a_scan_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SC_RD || r_state == S_SC_CHK) |-> (r_n < r_limit))
        else $error("scan count reached limit without stopping");

    // emit pass stays within the scanned byte count
    a_emit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EM_RD || r_state == S_EM_PUSH) |-> (r_cnt < r_n))
        else $error("emit pass ran past scanned bytes");

    // a returned byte comes only from the emit pass
    a_byte_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && push_data.read_valid) |-> (r_state == S_EM_PUSH))
        else $error("read byte pushed outside emit pass");

endmodule

### design/tle_store.sv
// ----------------------------------------------------------------------------
// tle_store: circular line store
// Single write port, single read port with registered read data. The read
// data register holds its value until the next read enable.
// ----------------------------------------------------------------------------
module tle_store #(
    parameter int STORE_DEPTH = 128
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [$clog2(STORE_DEPTH)-1:0] i_wr_addr,
    input  logic [7:0]                     i_wr_data,
    input  logic                           i_rd_en,
    input  logic [$clog2(STORE_DEPTH)-1:0] i_rd_addr,
    output logic [7:0]                     o_rd_data
);

    logic [7:0] r_mem [STORE_DEPTH];
    logic [7:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/tle_out_reg.sv
// ----------------------------------------------------------------------------
// tle_out_reg: output word register
// Holds one result word toward the downstream side; takes a new word when
// empty or when the held word leaves in the same cycle.
// ----------------------------------------------------------------------------
module tle_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tle_pkg::t_result i_data,
    output logic             o_free,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [1:0]       o_echo_code,
    output logic [7:0]       o_echo_byte,
    output logic             o_wake_reader,
    output logic [7:0]       o_read_byte,
    output logic             o_read_valid,
    output logic             o_line_ready,
    output logic             o_last
);
    import tle_pkg::*;

    logic    r_valid;
    t_result r_data;

    assign o_free = !r_valid || !i_out_stall;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_push;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_free && i_push) begin
            r_data <= i_data;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_echo_code   = r_data.echo_code;
    assign o_echo_byte   = r_data.echo_byte;
    assign o_wake_reader = r_data.wake_reader;
    assign o_read_byte   = r_data.read_byte;
    assign o_read_valid  = r_data.read_valid;
    assign o_line_ready  = r_data.line_ready;
    assign o_last        = r_data.last;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the terminal line edit buffer
// Drives key and read words through the valid/stall input channel, predicts
// every result word from a local model of the line store and pointers, and
// checks the output channel word by word. Both sides idle in random bursts;
// one long output hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module tb;
    import tle_pkg::*;

    // Request kinds carried on i_req_type
    localparam logic REQ_KEY  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam int MAX_READ     = 64;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int TAIL_WORDS   = 30;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 40;
    localparam int DRAIN_CYCLES = 300;
    localparam int RANDOM_WORDS = 20;

    typedef struct packed {
        logic       req_type;
        logic [7:0] key_byte;
        logic [6:0] read_limit;
    } t_in_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       i_req_type = 1'b0;
    logic [7:0] i_key_byte = 8'h00;
    logic [6:0] i_read_limit = 7'd0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [1:0] o_echo_code;
    logic [7:0] o_echo_byte;
    logic       o_wake_reader;
    logic [7:0] o_read_byte;
    logic       o_read_valid;
    logic       o_line_ready;
    logic       o_last;

    tty_line_edit_buffer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_key_byte    (i_key_byte),
        .i_read_limit  (i_read_limit),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_echo_code   (o_echo_code),
        .o_echo_byte   (o_echo_byte),
        .o_wake_reader (o_wake_reader),
        .o_read_byte   (o_read_byte),
        .o_read_valid  (o_read_valid),
        .o_line_ready  (o_line_ready),
        .o_last        (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_in_word pending_words[$];
    t_result  due_results[$];
    int       err_cnt = 0;
    int       n_total = 0;
    int       n_sent = 0;
    int       n_popped = 0;
    int       n_got = 0;
    int       cyc = 0;

    // Local copy of the line store; 7-bit pointers wrap at the depth of 128
    logic [7:0] line_mem [128];
    logic [6:0] wr_ptr = 7'd0;
    logic [6:0] rd_ptr = 7'd0;
    logic [6:0] ck_ptr = 7'd0;
    logic       store_full = 1'b0;

    // Predict the result words of one accepted word and queue them
    task automatic cook_word(input t_in_word w);
        t_result    r;
        logic [7:0] c;
        logic [7:0] b;
        logic [7:0] got [$];
        logic [6:0] p;
        logic       take;
        int         lim;
        r = '0;
        if (w.req_type == REQ_KEY) begin
            c = w.key_byte;
            take = 1'b1;
            if (store_full && c != CH_ETX && c != CH_BS)
                take = 1'b0;
            // last free slot: only newline, backspace and ETX get in
            if (take && wr_ptr == rd_ptr - 7'd1) begin
                if (c != CH_NL && c != CH_BS && c != CH_ETX)
                    take = 1'b0;
                else if (c == CH_NL)
                    store_full = 1'b1;
            end
            if (take) begin
                if (c == CH_NL || c == CH_EOT) begin
                    line_mem[wr_ptr] = c;
                    wr_ptr = wr_ptr + 7'd1;
                    ck_ptr = wr_ptr;
                    r.wake_reader = 1'b1;
                    if (c == CH_NL)
                        r.echo_code = ECHO_NL;
                end else if (c == CH_ETX) begin
                    // raw line dropped, blank line cooked in its place
                    line_mem[ck_ptr] = CH_NL;
                    wr_ptr = ck_ptr + 7'd1;
                    ck_ptr = wr_ptr;
                end else if (c == CH_BS) begin
                    if (wr_ptr != ck_ptr) begin
                        wr_ptr = wr_ptr - 7'd1;
                        r.echo_code = ECHO_BS;
                    end
                end else begin
                    line_mem[wr_ptr] = c;
                    wr_ptr = wr_ptr + 7'd1;
                    r.echo_code = ECHO_BYTE;
                    r.echo_byte = c;
                end
            end
            r.line_ready = (rd_ptr != ck_ptr);
            r.last = 1'b1;
            due_results.push_back(r);
        end else begin
            lim = (w.read_limit > MAX_READ) ? MAX_READ : int'(w.read_limit);
            if (lim != 0) begin
                p = rd_ptr;
                while (p != ck_ptr) begin
                    b = line_mem[p];
                    p = p + 7'd1;
                    // EOT is consumed but never returned
                    if (b == CH_EOT)
                        break;
                    got.push_back(b);
                    store_full = 1'b0;
                    if (b == CH_NL || got.size() >= lim)
                        break;
                end
                rd_ptr = p;
            end
            r.line_ready = (rd_ptr != ck_ptr);
            if (got.size() == 0) begin
                r.last = 1'b1;
                due_results.push_back(r);
            end else begin
                foreach (got[i]) begin
                    r.read_byte = got[i];
                    r.read_valid = 1'b1;
                    r.last = (i == got.size() - 1);
                    due_results.push_back(r);
                end
            end
        end
    endtask

    task automatic add_key(input logic [7:0] c);
        t_in_word w;
        w.req_type = REQ_KEY;
        w.key_byte = c;
        w.read_limit = 7'($urandom_range(0, 127));
        pending_words.push_back(w);
    endtask

    task automatic add_read(input int lim);
        t_in_word w;
        w.req_type = REQ_READ;
        w.key_byte = 8'($urandom_range(0, 255));
        w.read_limit = 7'(lim);
        pending_words.push_back(w);
    endtask

    function automatic int pick_limit();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return 0;
        if (roll < 20)
            return $urandom_range(MAX_READ + 1, 127);
        if (roll < 60)
            return $urandom_range(1, 8);
        return $urandom_range(1, MAX_READ);
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR @%0d: %s", cyc, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_error($sformatf("word %0d %s: got %0h want %0h", n_got, name, got, want));
    endtask

    // Input driver: next word from the pending queue, random gaps between words
    int gap_left = 0;
    t_in_word cur_word;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                cook_word(cur_word);
                n_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else begin
                    cur_word = pending_words.pop_front();
                    n_popped++;
                    i_req_type <= cur_word.req_type;
                    i_key_byte <= cur_word.key_byte;
                    i_read_limit <= cur_word.read_limit;
                    i_in_valid <= 1'b1;
                    // random gaps, but none in the first 16 words of every 64 and none at the tail
                    if (pending_words.size() > TAIL_WORDS && (n_popped % 64) >= 16 &&
                        $urandom_range(0, 5) == 0)
                        gap_left = $urandom_range(1, 9);
                end
            end
        end
    end

    // Output stall: one long hold-off and random bursts
    int  hold_left = 0;
    int  stall_left = 0;
    bit  hold_done = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!hold_done && n_sent >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (pending_words.size() > TAIL_WORDS && (n_got % 50) < 35 &&
                     $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 8);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Result monitor
    t_result want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_got++;
            if (due_results.size() == 0) begin
                report_error($sformatf("word %0d arrived with nothing expected", n_got));
            end else begin
                want = due_results.pop_front();
                check_field("echo_code", o_echo_code, want.echo_code);
                check_field("echo_byte", o_echo_byte, want.echo_byte);
                check_field("wake_reader", o_wake_reader, want.wake_reader);
                check_field("read_byte", o_read_byte, want.read_byte);
                check_field("read_valid", o_read_valid, want.read_valid);
                check_field("line_ready", o_line_ready, want.line_ready);
                check_field("last", o_last, want.last);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cyc++;
        if (cyc >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        int  n_rand;
        int  len;
        int  roll;
        int  n_reads;
        bit  flooded;
        n_rand = 0;
        flooded = 1'b0;
        foreach (line_mem[i])
            line_mem[i] = 8'h00;

        // directed: empty read, byte extremes, backspace down to empty line
        add_read(1);
        add_key(8'h41);
        add_key(8'h00);
        add_key(8'hFF);
        add_key(CH_BS);
        add_key(CH_BS);
        add_key(CH_BS);
        add_key(CH_BS);
        // cooked line, zero limit, limit past the maximum
        add_key(8'h68);
        add_key(8'h69);
        add_key(CH_NL);
        add_read(0);
        add_read(127);
        // EOT ends a read without being returned
        add_key(8'h78);
        add_key(CH_EOT);
        add_read(MAX_READ);
        // ETX leaves a blank line
        add_key(8'h71);
        add_key(CH_ETX);
        add_read(1);
        add_read(1);
        // partial read, then a read that only eats an EOT
        add_key(8'h80);
        add_key(8'h7F);
        add_key(CH_EOT);
        add_key(8'h6B);
        add_key(CH_NL);
        add_read(2);
        add_read(MAX_READ);
        add_read(MAX_READ);

        // random: mostly typed lines with reads, some loose words
        while (n_rand < RANDOM_WORDS) begin
            if (!flooded && n_rand >= 8) begin
                // overfill the store: last free slot, full flag, ETX overrun
                flooded = 1'b1;
                repeat (130) add_key(printable());
                add_key(CH_BS);
                add_key(printable());
                add_key(CH_NL);
                add_key(printable());
                add_key(CH_BS);
                add_read($urandom_range(1, 8));
                add_key(printable());
                add_key(CH_NL);
                add_key(CH_ETX);
                repeat (4) add_read(MAX_READ);
            end
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
                len = $urandom_range(0, 12);
                repeat (len) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 78)
                        add_key(printable());
                    else if (roll < 90)
                        add_key(8'($urandom_range(0, 255)));
                    else
                        add_key(CH_BS);
                    n_rand++;
                end
                roll = $urandom_range(0, 99);
                if (roll < 60)
                    add_key(CH_NL);
                else if (roll < 78)
                    add_key(CH_EOT);
                else if (roll < 88)
                    add_key(CH_ETX);
                if (roll < 88)
                    n_rand++;
                n_reads = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 3) : 0;
                repeat (n_reads) begin
                    add_read(pick_limit());
                    n_rand++;
                end
            end else if (roll < 88) begin
                add_read(pick_limit());
                n_rand++;
            end else begin
                add_key(8'($urandom_range(0, 255)));
                n_rand++;
            end
        end
        // drain whatever is still cooked
        repeat (3) add_read(MAX_READ);
        n_total = pending_words.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent < n_total)
            @(posedge i_clk);
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
